>>> sv/urtb_pkg.sv
// Package with the beat types, opcodes and constants of the UART ring buffer block.
package urtb_pkg;

  localparam logic [2:0] OP_LINE_IN    = 3'd0;
  localparam logic [2:0] OP_HOST_READ  = 3'd1;
  localparam logic [2:0] OP_HOST_WRITE = 3'd2;
  localparam logic [2:0] OP_TX_READY   = 3'd3;
  localparam logic [2:0] OP_CLR_PTRS   = 3'd4;
  localparam logic [2:0] OP_CLR_ERRS   = 3'd5;
  localparam logic [2:0] OP_SET_END    = 3'd6;

  localparam int unsigned ERR_RX_FULL  = 0;
  localparam int unsigned ERR_TX_FULL  = 1;
  localparam int unsigned ERR_NO_DATA  = 2;

  localparam logic [7:0] END_CHAR_RESET = 8'd42;
  localparam logic [7:0] END_FLAG_SET   = 8'h01;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [2:0] error_clear_mask;
  } urtb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_line_valid;
    logic       to_host_valid;
    logic [2:0] error_flags;
    logic [5:0] rx_waiting;
    logic [5:0] tx_waiting;
    logic [7:0] end_flag_value;
    logic       tx_irq_enabled;
  } urtb_out_t;

endpackage

>>> sv/uart_rx_tx_ring_buffers.sv
// Top level: receive and transmit byte rings with sticky errors and an end-of-message flag.
//
// The input channel (in_valid, in_stall, in_data) carries one command beat: a line
// byte in, a host read or write, a transmitter-ready pop, a pointer clear, an error
// clear or an end-flag write. Every accepted beat yields exactly one result beat on
// out_valid/out_stall/out_data, in the cycle after acceptance, with the popped byte and
// the status after the update. Each ring keeps one slot free, so it holds at most
// DEPTH-1 bytes.
// A new beat can be taken every cycle while in_stall is low. Each command does at most
// one access to a ring memory; a pop reads through the memory's single registered
// read port. While a result waits and out_stall is high, in_stall is high, so no
// beat is lost. The end character is written through cfg_we and cfg_wdata; the user
// must do so only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) zeroes all pointers, errors, the end flag and the
// interrupt enable, sets the end character to '*' and drops out_valid. The ring
// memories are not cleared; an entry is only read after it was written.
module uart_rx_tx_ring_buffers
  import urtb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  urtb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output urtb_out_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int unsigned RX_PW = $clog2(RX_DEPTH);
  localparam int unsigned TX_PW = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW = (RX_PW + 1 > 6) ? RX_PW + 1 : 6;
  localparam int unsigned TX_CW = (TX_PW + 1 > 6) ? TX_PW + 1 : 6;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_PW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt, rx_head_adv, rx_tail_adv;
  logic [TX_PW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt, tx_head_adv, tx_tail_adv;
  logic [2:0]       err_r, err_nxt;
  logic [7:0]       end_flag_r, end_flag_nxt;
  logic             irq_r, irq_nxt;
  logic [7:0]       end_char_r;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_rd_r, tx_rd_r;
  logic [RX_CW-1:0] rx_cnt;
  logic [TX_CW-1:0] tx_cnt;

  logic             out_valid_r;
  logic             line_v_r, host_v_r;
  logic [5:0]       rx_wait_r, tx_wait_r;
  logic             accept;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  assign rx_head_adv = (rx_head_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_adv = (rx_tail_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_adv = (tx_head_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_adv = (tx_tail_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + 1'b1;

  always_comb begin
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    err_nxt      = err_r;
    end_flag_nxt = end_flag_r;
    irq_nxt      = irq_r;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    unique case (in_data.opcode)
      OP_LINE_IN: begin
        if (rx_head_adv == rx_tail_r) begin
          err_nxt[ERR_RX_FULL] = 1'b1;
        end else begin
          rx_head_nxt = rx_head_adv;
          rx_we       = 1'b1;
          if (in_data.data_byte == end_char_r) end_flag_nxt = END_FLAG_SET;
        end
      end
      OP_HOST_READ: begin
        if (rx_tail_r == rx_head_r) begin
          err_nxt[ERR_NO_DATA] = 1'b1;
        end else begin
          rx_tail_nxt = rx_tail_adv;
          rx_re       = 1'b1;
        end
      end
      OP_HOST_WRITE: begin
        if (tx_head_adv == tx_tail_r) begin
          err_nxt[ERR_TX_FULL] = 1'b1;
        end else begin
          tx_head_nxt = tx_head_adv;
          tx_we       = 1'b1;
          irq_nxt     = 1'b1;
        end
      end
      OP_TX_READY: begin
        if (tx_tail_r != tx_head_r) begin
          tx_tail_nxt = tx_tail_adv;
          tx_re       = 1'b1;
        end else begin
          irq_nxt = 1'b0;
        end
      end
      OP_CLR_PTRS: begin
        rx_head_nxt = '0;
        rx_tail_nxt = '0;
        tx_head_nxt = '0;
        tx_tail_nxt = '0;
      end
      OP_CLR_ERRS: err_nxt = err_r & ~in_data.error_clear_mask;
      OP_SET_END:  end_flag_nxt = in_data.data_byte;
      default: ;
    endcase
  end

  // Fill counts after the update; the wrapped case adds the depth back.
  always_comb begin
    if (rx_head_nxt >= rx_tail_nxt) begin
      rx_cnt = RX_CW'(rx_head_nxt) - RX_CW'(rx_tail_nxt);
    end else begin
      rx_cnt = RX_CW'(RX_DEPTH) - RX_CW'(rx_tail_nxt) + RX_CW'(rx_head_nxt);
    end
    if (tx_head_nxt >= tx_tail_nxt) begin
      tx_cnt = TX_CW'(tx_head_nxt) - TX_CW'(tx_tail_nxt);
    end else begin
      tx_cnt = TX_CW'(TX_DEPTH) - TX_CW'(tx_tail_nxt) + TX_CW'(tx_head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx_we) rx_mem[rx_head_adv] <= in_data.data_byte;
    if (accept && rx_re) rx_rd_r <= rx_mem[rx_tail_adv];
  end

  always_ff @(posedge clk) begin
    if (accept && tx_we) tx_mem[tx_head_adv] <= in_data.data_byte;
    if (accept && tx_re) tx_rd_r <= tx_mem[tx_tail_adv];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      err_r       <= '0;
      end_flag_r  <= '0;
      irq_r       <= 1'b0;
      end_char_r  <= END_CHAR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) end_char_r <= cfg_wdata;
      if (accept) begin
        rx_head_r   <= rx_head_nxt;
        rx_tail_r   <= rx_tail_nxt;
        tx_head_r   <= tx_head_nxt;
        tx_tail_r   <= tx_tail_nxt;
        err_r       <= err_nxt;
        end_flag_r  <= end_flag_nxt;
        irq_r       <= irq_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_v_r  <= tx_re;
      host_v_r  <= rx_re;
      rx_wait_r <= rx_cnt[5:0];
      tx_wait_r <= tx_cnt[5:0];
    end
  end

  always_comb begin
    out_data.out_byte       = host_v_r ? rx_rd_r : (line_v_r ? tx_rd_r : 8'd0);
    out_data.to_line_valid  = line_v_r;
    out_data.to_host_valid  = host_v_r;
    out_data.error_flags    = err_r;
    out_data.rx_waiting     = rx_wait_r;
    out_data.tx_waiting     = tx_wait_r;
    out_data.end_flag_value = end_flag_r;
    out_data.tx_irq_enabled = irq_r;
  end

  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.to_line_valid && out_data.to_host_valid))
    else $error("result beat marked for both line and host");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == OP_HOST_READ && rx_head_r == rx_tail_r)
      |=> (out_data.error_flags[ERR_NO_DATA] && !out_data.to_host_valid))
    else $error("read of empty receive ring not flagged");

  a_clear_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == OP_CLR_PTRS)
      |=> (out_data.rx_waiting == 6'd0 && out_data.tx_waiting == 6'd0))
    else $error("pointer clear left bytes waiting");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(rx_head_r) < RX_DEPTH) && (32'(rx_tail_r) < RX_DEPTH) &&
    (32'(tx_head_r) < TX_DEPTH) && (32'(tx_tail_r) < TX_DEPTH))
    else $error("ring pointer out of range");

endmodule
